@@ design/att_pkg.sv @@
// Shared types and constants for the text terminal.
`timescale 1ns / 1ps
package att_pkg;
  localparam int ROWS_DEF   = 25;
  localparam int COLS_DEF   = 80;
  localparam int PDEPTH_DEF = 15;

  localparam int              PARAM_W   = 14;
  localparam logic [13:0]     PARAM_MAX = 14'd9999;

  localparam logic [1:0] CMD_PRINT = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TAKE  = 2'd2;
  localparam logic [1:0] CMD_RESET = 2'd3;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_QUES  = 8'h3F;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_FIN_LO = 8'h40;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_J = 8'h4A;
  localparam logic [7:0] CH_K = 8'h4B;
  localparam logic [7:0] CH_F = 8'h66;

  typedef struct packed {
    logic       clear;
    logic       push;
    logic [7:0] data;
    logic       start;
  } scan_ctl_t;

  typedef struct packed {
    logic        busy;
    logic [13:0] p0;
    logic        s0;
    logic [13:0] p1;
    logic        s1;
  } scan_res_t;
endpackage

@@ design/att_param_scan.sv @@
// Escape parameter buffer and serial decimal parser, one byte per cycle.
`timescale 1ns / 1ps
module att_param_scan #(
  parameter int PDEPTH = att_pkg::PDEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  att_pkg::scan_ctl_t ctl,
  output att_pkg::scan_res_t res
);
  import att_pkg::*;

  localparam int CW = $clog2(PDEPTH + 1);
  localparam int IW = $clog2(PDEPTH);

  logic [7:0]    buf_r [PDEPTH];
  logic [CW-1:0] cnt_r, idx_r;
  logic          busy_r, seen_r;
  logic [1:0]    semi_r;
  logic [13:0]   val_r, p0_r, p1_r;
  logic          s0_r, s1_r;

  logic [7:0]  ch;
  logic [17:0] acc;

  assign ch  = buf_r[idx_r[IW-1:0]];
  assign acc = 18'(val_r) * 18'd10 + 18'(ch - CH_ZERO);

  // buffer fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.clear) begin
      cnt_r <= '0;
    end else if (ctl.push && cnt_r < CW'(PDEPTH)) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.clear && cnt_r < CW'(PDEPTH)) begin
      buf_r[cnt_r[IW-1:0]] <= ctl.data;
    end
  end

  // serial scan: first two fields kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
      val_r  <= '0;
      seen_r <= 1'b0;
      semi_r <= 2'd0;
      s0_r   <= 1'b0;
      s1_r   <= 1'b0;
    end else if (busy_r) begin
      if (idx_r == cnt_r) begin
        busy_r <= 1'b0;
        if (semi_r == 2'd0) begin
          p0_r <= val_r;
          s0_r <= seen_r;
        end
        if (semi_r == 2'd1) begin
          p1_r <= val_r;
          s1_r <= seen_r;
        end
      end else begin
        idx_r <= idx_r + 1'b1;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
          val_r  <= (acc > 18'(PARAM_MAX)) ? PARAM_MAX : acc[13:0];
          seen_r <= 1'b1;
        end else if (ch == CH_SEMI) begin
          if (semi_r == 2'd0) begin
            p0_r <= val_r;
            s0_r <= seen_r;
          end
          if (semi_r == 2'd1) begin
            p1_r <= val_r;
            s1_r <= seen_r;
          end
          if (semi_r != 2'd2) semi_r <= semi_r + 2'd1;
          val_r  <= '0;
          seen_r <= 1'b0;
        end
      end
    end
  end

  assign res = '{busy: busy_r, p0: p0_r, s0: s0_r, p1: p1_r, s1: s1_r};
endmodule

@@ design/ansi_text_terminal.sv @@
// Top level of the text terminal: command sequencer, cell memory, result register.
`timescale 1ns / 1ps
// Plain print, read and take-dirty pass through S_DONE, which registers the result word;
// no new word is taken until the sequencer is back in S_IDLE. Tab: S_TAB writes the pad
// spaces. Escape final: S_PARSE, then S_FINAL. Scroll: S_COPY moves each row up, then
// S_FILL blanks the bottom row; erase/clear one cell per cycle. A stalled result word
// holds off the next one. Reset (rst_n low, synchronous) space-fills all ROWS*COLS
// cells; in_stall stays high until it ends. Config writes always taken.
module ansi_text_terminal #(
  parameter int ROWS   = att_pkg::ROWS_DEF,
  parameter int COLS   = att_pkg::COLS_DEF,
  parameter int PDEPTH = att_pkg::PDEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_enabled,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [7:0] in_byte_in,
  input  logic [4:0] in_read_row,
  input  logic [6:0] in_read_col,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_cell_char,
  output logic [4:0] out_cursor_row,
  output logic [6:0] out_cursor_col,
  output logic       out_dirty
);
  import att_pkg::*;

  localparam int NCELL = ROWS * COLS;
  localparam int AW    = $clog2(NCELL);
  localparam int YW    = $clog2(ROWS);
  localparam int XW    = $clog2(COLS);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_TAB   = 3'd2;
  localparam logic [2:0] S_PARSE = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;
  localparam logic [2:0] S_COPY  = 3'd5;
  localparam logic [2:0] S_FILL  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [1:0] PH_GROUND = 2'd0;
  localparam logic [1:0] PH_ESC    = 2'd1;
  localparam logic [1:0] PH_CSI    = 2'd2;

  // cell memory: one write, one registered read per cycle
  logic [6:0]    mem [NCELL];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [6:0]    mem_wdata, mem_rd_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rd_r <= mem[mem_raddr];
  end

  // state
  logic [2:0]    state_r, state_nxt;
  logic [YW-1:0] cur_y_r, cur_y_nxt;
  logic [XW-1:0] cur_x_r, cur_x_nxt;
  logic          dirty_r, dirty_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic          enabled_r;
  logic [AW-1:0] fill_ptr_r, fill_ptr_nxt, fill_end_r, fill_end_nxt;
  logic [AW-1:0] cp_r, cp_nxt;
  logic          pend_r, pend_nxt;
  logic [1:0]    cmd_r, cmd_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          rdok_r, rdok_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [6:0]    out_cell_r, out_cell_nxt;
  logic [4:0]    out_row_r, out_row_nxt;
  logic [6:0]    out_col_r, out_col_nxt;
  logic          out_dirty_r, out_dirty_nxt;

  scan_ctl_t sc_ctl;
  scan_res_t sc_res;

  att_param_scan #(.PDEPTH(PDEPTH)) u_scan (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (sc_ctl),
    .res  (sc_res)
  );

  // helpers
  logic          accept, put_wrap, put_bottom;
  logic [AW-1:0] cur_lin, row_lin, rd_lin;
  logic          rd_in_range;
  logic [6:0]    print_ch;
  logic [13:0]   n0, e0, n1;
  logic [14:0]   bsum, csum;

  assign accept     = in_valid && !in_stall;
  assign put_wrap   = (cur_x_r == XW'(COLS - 1));
  assign put_bottom = (cur_y_r == YW'(ROWS - 1));
  assign row_lin    = AW'(int'(cur_y_r) * COLS);
  assign cur_lin    = row_lin + AW'(cur_x_r);
  assign rd_in_range = (int'(in_read_row) < ROWS) && (int'(in_read_col) < COLS);
  assign rd_lin     = AW'(int'(in_read_row) * COLS + int'(in_read_col));
  assign print_ch   = (in_byte_in < CH_SPACE || in_byte_in > CH_TILDE) ?
                      CH_QUES[6:0] : in_byte_in[6:0];
  assign n0   = sc_res.s0 ? sc_res.p0 : 14'd1;
  assign e0   = sc_res.s0 ? sc_res.p0 : 14'd0;
  assign n1   = sc_res.s1 ? sc_res.p1 : 14'd1;
  assign bsum = 15'(n0) + 15'(cur_y_r);
  assign csum = 15'(n0) + 15'(cur_x_r);

  // 1-based position to 0-based index, clamped to size
  function automatic logic [13:0] clamp_pos(logic [13:0] n, logic [13:0] size);
    logic [13:0] m;
    m = ((n == 14'd0) ? 14'd1 : n) - 14'd1;
    return (m < size) ? m : size - 14'd1;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    cur_y_nxt     = cur_y_r;
    cur_x_nxt     = cur_x_r;
    dirty_nxt     = dirty_r;
    phase_nxt     = phase_r;
    fill_ptr_nxt  = fill_ptr_r;
    fill_end_nxt  = fill_end_r;
    cp_nxt        = cp_r;
    pend_nxt      = pend_r;
    cmd_nxt       = cmd_r;
    byte_nxt      = byte_r;
    rdok_nxt      = rdok_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_cell_nxt  = out_cell_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_dirty_nxt = out_dirty_r;
    mem_we        = 1'b0;
    mem_waddr     = cur_lin;
    mem_wdata     = CH_SPACE[6:0];
    mem_re        = 1'b0;
    mem_raddr     = rd_lin;
    sc_ctl        = '{clear: 1'b0, push: 1'b0, data: in_byte_in, start: 1'b0};

    unique case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = fill_ptr_r;
        fill_ptr_nxt = fill_ptr_r + 1'b1;
        if (fill_ptr_r == AW'(NCELL - 1)) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_command;
          byte_nxt  = in_byte_in;
          rdok_nxt  = 1'b0;
          state_nxt = S_DONE;
          unique case (in_command)
            CMD_PRINT: begin
              if (enabled_r) begin
                unique case (phase_r)
                  PH_ESC: begin
                    phase_nxt    = (in_byte_in == CH_LBRK) ? PH_CSI : PH_GROUND;
                    sc_ctl.clear = 1'b1;
                  end
                  PH_CSI: begin
                    if ((in_byte_in >= CH_ZERO && in_byte_in <= CH_NINE) ||
                        in_byte_in == CH_SEMI || in_byte_in == CH_QUES) begin
                      sc_ctl.push = 1'b1;
                    end else if (in_byte_in >= CH_FIN_LO && in_byte_in <= CH_TILDE) begin
                      phase_nxt    = PH_GROUND;
                      sc_ctl.start = 1'b1;
                      state_nxt    = S_PARSE;
                    end else begin
                      phase_nxt    = PH_GROUND;
                      sc_ctl.clear = 1'b1;
                    end
                  end
                  default: begin
                    case (in_byte_in)
                      CH_FF: begin
                        cur_y_nxt    = '0;
                        cur_x_nxt    = '0;
                        dirty_nxt    = 1'b1;
                        sc_ctl.clear = 1'b1;
                        fill_ptr_nxt = '0;
                        fill_end_nxt = AW'(NCELL - 1);
                        state_nxt    = S_FILL;
                      end
                      CH_CR: begin
                        cur_x_nxt = '0;
                        dirty_nxt = 1'b1;
                      end
                      CH_LF: begin
                        cur_x_nxt = '0;
                        dirty_nxt = 1'b1;
                        if (put_bottom) begin
                          cp_nxt    = '0;
                          pend_nxt  = 1'b0;
                          state_nxt = S_COPY;
                        end else begin
                          cur_y_nxt = cur_y_r + 1'b1;
                        end
                      end
                      CH_BS, CH_DEL: begin
                        dirty_nxt = 1'b1;
                        if (cur_x_r != '0) begin
                          cur_x_nxt = cur_x_r - 1'b1;
                          mem_we    = 1'b1;
                          mem_waddr = cur_lin - 1'b1;
                        end
                      end
                      CH_TAB: state_nxt = S_TAB;
                      CH_ESC: phase_nxt = PH_ESC;
                      default: begin
                        mem_we    = 1'b1;
                        mem_wdata = print_ch;
                        dirty_nxt = 1'b1;
                        if (put_wrap) begin
                          cur_x_nxt = '0;
                          if (put_bottom) begin
                            cp_nxt    = '0;
                            pend_nxt  = 1'b0;
                            state_nxt = S_COPY;
                          end else begin
                            cur_y_nxt = cur_y_r + 1'b1;
                          end
                        end else begin
                          cur_x_nxt = cur_x_r + 1'b1;
                        end
                      end
                    endcase
                  end
                endcase
              end
            end
            CMD_READ: begin
              if (rd_in_range) begin
                mem_re   = 1'b1;
                rdok_nxt = 1'b1;
              end
            end
            CMD_TAKE: ;
            default: begin
              cur_y_nxt    = '0;
              cur_x_nxt    = '0;
              dirty_nxt    = 1'b1;
              phase_nxt    = PH_GROUND;
              sc_ctl.clear = 1'b1;
              fill_ptr_nxt = '0;
              fill_end_nxt = AW'(NCELL - 1);
              state_nxt    = S_FILL;
            end
          endcase
        end
      end

      // one space per cycle until a tab stop or a wrap
      S_TAB: begin
        mem_we    = 1'b1;
        dirty_nxt = 1'b1;
        if (put_wrap) begin
          cur_x_nxt = '0;
          if (put_bottom) begin
            cp_nxt    = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_COPY;
          end else begin
            cur_y_nxt = cur_y_r + 1'b1;
            state_nxt = S_DONE;
          end
        end else begin
          cur_x_nxt = cur_x_r + 1'b1;
          if (cur_x_nxt[1:0] == 2'd0) state_nxt = S_DONE;
        end
      end

      S_PARSE: begin
        if (!sc_res.busy) state_nxt = S_FINAL;
      end

      S_FINAL: begin
        sc_ctl.clear = 1'b1;
        state_nxt    = S_DONE;
        case (byte_r)
          CH_A: begin
            cur_y_nxt = (n0 > 14'(cur_y_r)) ? '0 : YW'(14'(cur_y_r) - n0);
            dirty_nxt = 1'b1;
          end
          CH_B: begin
            cur_y_nxt = (bsum >= 15'(ROWS - 1)) ? YW'(ROWS - 1) : YW'(bsum);
            dirty_nxt = 1'b1;
          end
          CH_C: begin
            cur_x_nxt = (csum >= 15'(COLS - 1)) ? XW'(COLS - 1) : XW'(csum);
            dirty_nxt = 1'b1;
          end
          CH_D: begin
            cur_x_nxt = (n0 > 14'(cur_x_r)) ? '0 : XW'(14'(cur_x_r) - n0);
            dirty_nxt = 1'b1;
          end
          CH_G: begin
            cur_x_nxt = XW'(clamp_pos(n0, 14'(COLS)));
            dirty_nxt = 1'b1;
          end
          CH_H, CH_F: begin
            cur_y_nxt = YW'(clamp_pos(n0, 14'(ROWS)));
            cur_x_nxt = XW'(clamp_pos(n1, 14'(COLS)));
            dirty_nxt = 1'b1;
          end
          CH_J: begin
            dirty_nxt = 1'b1;
            state_nxt = S_FILL;
            if (e0 == 14'd0) begin
              fill_ptr_nxt = cur_lin;
              fill_end_nxt = AW'(NCELL - 1);
            end else if (e0 == 14'd1) begin
              fill_ptr_nxt = '0;
              fill_end_nxt = cur_lin;
            end else begin
              cur_y_nxt    = '0;
              cur_x_nxt    = '0;
              fill_ptr_nxt = '0;
              fill_end_nxt = AW'(NCELL - 1);
            end
          end
          CH_K: begin
            dirty_nxt = 1'b1;
            state_nxt = S_FILL;
            if (e0 == 14'd0) begin
              fill_ptr_nxt = cur_lin;
              fill_end_nxt = row_lin + AW'(COLS - 1);
            end else if (e0 == 14'd1) begin
              fill_ptr_nxt = row_lin;
              fill_end_nxt = cur_lin;
            end else begin
              fill_ptr_nxt = row_lin;
              fill_end_nxt = row_lin + AW'(COLS - 1);
            end
          end
          default: ;
        endcase
      end

      // scroll: read cell one row down, write it back in the next cycle
      S_COPY: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = cp_r - 1'b1;
          mem_wdata = mem_rd_r;
        end
        if (cp_r < AW'(NCELL - COLS)) begin
          mem_re    = 1'b1;
          mem_raddr = cp_r + AW'(COLS);
          cp_nxt    = cp_r + 1'b1;
          pend_nxt  = 1'b1;
        end else begin
          fill_ptr_nxt = AW'(NCELL - COLS);
          fill_end_nxt = AW'(NCELL - 1);
          state_nxt    = S_FILL;
        end
      end

      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_ptr_r;
        fill_ptr_nxt = fill_ptr_r + 1'b1;
        if (fill_ptr_r == fill_end_r) state_nxt = S_DONE;
      end

      default: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = rdok_r ? mem_rd_r : 7'd0;
          out_row_nxt   = 5'(cur_y_r);
          out_col_nxt   = 7'(cur_x_r);
          out_dirty_nxt = dirty_r;
          if (cmd_r == CMD_TAKE) dirty_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cur_y_r     <= '0;
      cur_x_r     <= '0;
      dirty_r     <= 1'b1;
      phase_r     <= PH_GROUND;
      enabled_r   <= 1'b0;
      fill_ptr_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_y_r     <= cur_y_nxt;
      cur_x_r     <= cur_x_nxt;
      dirty_r     <= dirty_nxt;
      phase_r     <= phase_nxt;
      fill_ptr_r  <= fill_ptr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) enabled_r <= cfg_enabled;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    fill_end_r  <= fill_end_nxt;
    cp_r        <= cp_nxt;
    cmd_r       <= cmd_nxt;
    byte_r      <= byte_nxt;
    rdok_r      <= rdok_nxt;
    out_cell_r  <= out_cell_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_dirty_r <= out_dirty_nxt;
  end

  assign cfg_ready      = 1'b1;
  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_cell_char  = out_cell_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_dirty      = out_dirty_r;
endmodule

@@ design/att_checker.sv @@
// Port-level checks for the text terminal, bound to the top level.
`timescale 1ns / 1ps
module att_props #(
  parameter int ROWS = att_pkg::ROWS_DEF,
  parameter int COLS = att_pkg::COLS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] out_cell_char,
  input logic [4:0] out_cursor_row,
  input logic [6:0] out_cursor_col,
  input logic       out_dirty
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_cell_char) && $stable(out_cursor_row) &&
      $stable(out_cursor_col) && $stable(out_dirty))
    else $error("stalled result word changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second command taken before first finished");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_cursor_row) < ROWS) && (int'(out_cursor_col) < COLS))
    else $error("cursor outside screen");
endmodule

bind ansi_text_terminal att_props #(.ROWS(ROWS), .COLS(COLS)) u_att_props (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_cell_char (out_cell_char),
  .out_cursor_row(out_cursor_row),
  .out_cursor_col(out_cursor_col),
  .out_dirty     (out_dirty)
);
